// ===== rtl/dtes_pkg.sv =====
// Package for the date text to epoch seconds block: item types, status codes,
// stage records and the month offset table. No dependencies.
`default_nettype none

package dtes_pkg;

   localparam logic [7:0] SlashChar = 8'h2F;
   localparam logic [7:0] ZeroChar  = 8'h30;
   localparam logic [7:0] NineChar  = 8'h39;

   // Days from 0000-03-01 to 1970-01-01
   localparam int unsigned EpochShift = 719468;
   localparam int unsigned SecsPerDay = 86400;
   // floor(yy / 100) == (yy * Recip100) >> Recip100Shift for yy below 10000
   localparam int unsigned Recip100      = 5243;
   localparam int unsigned Recip100Shift = 19;

   localparam int unsigned YearWidth = 14;
   localparam int unsigned DaysWidth = 22;
   localparam int unsigned SecsWidth = 38;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_SEP   = 3'd1,
      ST_MONTH = 3'd2,
      ST_DAY   = 3'd3,
      ST_EARLY = 3'd4,
      ST_DIGIT = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] day_tens_char;
      logic [7:0] day_ones_char;
      logic [7:0] first_separator_char;
      logic [7:0] month_tens_char;
      logic [7:0] month_ones_char;
      logic [7:0] second_separator_char;
      logic [7:0] year_thousands_char;
      logic [7:0] year_hundreds_char;
      logic [7:0] year_tens_char;
      logic [7:0] year_ones_char;
   } req_type;

   typedef struct packed {
      logic [SecsWidth-1:0] epoch_seconds;
      logic [2:0]           status;
   } rsp_type;

   // Parsed date after the first stage
   typedef struct packed {
      logic                 valid;
      status_type           status;
      logic [6:0]           day;
      logic [6:0]           month;
      logic [YearWidth-1:0] year;
   } parse_type;

   // Day count after the day stages
   typedef struct packed {
      logic                 valid;
      status_type           status;
      logic [DaysWidth-1:0] days;
   } days_type;

   // Day of year counted from March 1, for months numbered from March
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] start;
      case (mp)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd61;
         4'd3:    start = 9'd92;
         4'd4:    start = 9'd122;
         4'd5:    start = 9'd153;
         4'd6:    start = 9'd184;
         4'd7:    start = 9'd214;
         4'd8:    start = 9'd245;
         4'd9:    start = 9'd275;
         4'd10:   start = 9'd306;
         4'd11:   start = 9'd337;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/dtes_parse.sv =====
// First stage: separator and digit checks, digit text to day, month, year.
// Depends on dtes_pkg.
`default_nettype none

module dtes_parse (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 accept,
   input  dtes_pkg::req_type   req_item,
   output dtes_pkg::parse_type parsed
);

   dtes_pkg::parse_type parse_ff, parse_in;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= dtes_pkg::ZeroChar) && (c <= dtes_pkg::NineChar);
   endfunction

   always_comb begin
      logic sep_ok;
      logic dig_ok;
      sep_ok = (req_item.first_separator_char == dtes_pkg::SlashChar) &&
               (req_item.second_separator_char == dtes_pkg::SlashChar);
      dig_ok = is_digit(req_item.day_tens_char) && is_digit(req_item.day_ones_char) &&
               is_digit(req_item.month_tens_char) && is_digit(req_item.month_ones_char) &&
               is_digit(req_item.year_thousands_char) &&
               is_digit(req_item.year_hundreds_char) &&
               is_digit(req_item.year_tens_char) && is_digit(req_item.year_ones_char);

      parse_in.valid = accept;
      if (!sep_ok) begin
         parse_in.status = dtes_pkg::ST_SEP;
      end else if (!dig_ok) begin
         parse_in.status = dtes_pkg::ST_DIGIT;
      end else begin
         parse_in.status = dtes_pkg::ST_OK;
      end
      // Low nibble of an ASCII digit is its value
      parse_in.day   = 7'(req_item.day_tens_char[3:0]) * 7'd10 +
                       7'(req_item.day_ones_char[3:0]);
      parse_in.month = 7'(req_item.month_tens_char[3:0]) * 7'd10 +
                       7'(req_item.month_ones_char[3:0]);
      parse_in.year  = 14'(req_item.year_thousands_char[3:0]) * 14'd1000 +
                       14'(req_item.year_hundreds_char[3:0]) * 14'd100 +
                       14'(req_item.year_tens_char[3:0]) * 14'd10 +
                       14'(req_item.year_ones_char[3:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff <= '0;
      end else begin
         parse_ff <= parse_in;
      end
   end

   assign parsed = parse_ff;

endmodule

`default_nettype wire

// ===== rtl/dtes_days.sv =====
// Stages two to four: range checks, March-based year and day of year,
// century terms by reciprocal multiply, day count since the epoch.
// Depends on dtes_pkg.
`default_nettype none

module dtes_days (
   input  wire                 clock,
   input  wire                 reset,
   input  dtes_pkg::parse_type parsed,
   output dtes_pkg::days_type  days_out
);

   localparam int unsigned YW = dtes_pkg::YearWidth;

   // Stage two: checks, shifted year, day of year
   logic                v2_ff, v2_in;
   dtes_pkg::status_type st2_ff, st2_in;
   logic                early2_ff, early2_in;
   logic [YW-1:0]       yy2_ff, yy2_in;
   logic [8:0]          doy2_ff, doy2_in;

   always_comb begin
      logic       march;
      logic [3:0] mp;
      march  = parsed.month <= 7'd2;
      mp     = march ? 4'(parsed.month + 7'd9) : 4'(parsed.month - 7'd3);
      v2_in  = parsed.valid;
      st2_in = parsed.status;
      if (parsed.status == dtes_pkg::ST_OK) begin
         if (parsed.month < 7'd1 || parsed.month > 7'd12) begin
            st2_in = dtes_pkg::ST_MONTH;
         end else if (parsed.day < 7'd1 || parsed.day > 7'd31) begin
            st2_in = dtes_pkg::ST_DAY;
         end
      end
      // January or February of year zero belongs to year minus one
      early2_in = march && (parsed.year == '0);
      yy2_in    = parsed.year - YW'(march);
      doy2_in   = dtes_pkg::month_start(mp) + 9'(parsed.day) - 9'd1;
   end

   always_ff @(posedge clock) begin
      st2_ff    <= st2_in;
      early2_ff <= early2_in;
      yy2_ff    <= yy2_in;
      doy2_ff   <= doy2_in;
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
   end

   // Stage three: the two products
   logic                v3_ff;
   dtes_pkg::status_type st3_ff;
   logic                early3_ff;
   logic [YW-1:0]       yy3_ff;
   logic [8:0]          doy3_ff;
   logic [26:0]         recip3_ff, recip3_in;
   logic [22:0]         y365_3_ff, y365_3_in;

   assign recip3_in = 27'(yy2_ff) * 27'(dtes_pkg::Recip100);
   assign y365_3_in = 23'(yy2_ff) * 23'd365;

   always_ff @(posedge clock) begin
      st3_ff    <= st2_ff;
      early3_ff <= early2_ff;
      yy3_ff    <= yy2_ff;
      doy3_ff   <= doy2_ff;
      recip3_ff <= recip3_in;
      y365_3_ff <= y365_3_in;
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   // Stage four: sum the day terms and compare with the epoch
   dtes_pkg::days_type days_ff, days_in;

   always_comb begin
      logic [6:0]  q100;
      logic [6:0]  q400;
      logic [22:0] days0;
      q100  = 7'(recip3_ff >> dtes_pkg::Recip100Shift);
      q400  = q100 >> 2;
      days0 = y365_3_ff + 23'(yy3_ff >> 2) - 23'(q100) + 23'(q400) + 23'(doy3_ff);
      days_in.valid  = v3_ff;
      days_in.status = st3_ff;
      if (st3_ff == dtes_pkg::ST_OK &&
          (early3_ff || days0 < 23'(dtes_pkg::EpochShift))) begin
         days_in.status = dtes_pkg::ST_EARLY;
      end
      days_in.days = dtes_pkg::DaysWidth'(days0 - 23'(dtes_pkg::EpochShift));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         days_ff <= '0;
      end else begin
         days_ff <= days_in;
      end
   end

   assign days_out = days_ff;

endmodule

`default_nettype wire

// ===== rtl/dtes_scale.sv =====
// Last stage: day count times seconds per day, zero on any reject.
// Depends on dtes_pkg.
`default_nettype none

module dtes_scale (
   input  wire                clock,
   input  wire                reset,
   input  dtes_pkg::days_type days_in,
   output logic               rsp_valid,
   output dtes_pkg::rsp_type  rsp_item
);

   localparam int unsigned SW = dtes_pkg::SecsWidth;

   logic              valid_ff;
   dtes_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      logic [SW:0] product;
      product = (SW+1)'(days_in.days) * (SW+1)'(dtes_pkg::SecsPerDay);
      rsp_in.status = days_in.status;
      if (days_in.status == dtes_pkg::ST_OK) begin
         rsp_in.epoch_seconds = product[SW-1:0];
      end else begin
         rsp_in.epoch_seconds = '0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= days_in.valid;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/date_text_to_epoch_seconds.sv =====
// Top level: DD/MM/YYYY text to seconds since 1970-01-01 at midnight.
// Depends on dtes_pkg, dtes_parse, dtes_days and dtes_scale.
//
//   channel   ports                   direction   handshake
//   request   start, busy, req_item   in          taken when start && !busy
//   response  rsp_valid, rsp_item     out         one-cycle strobe, no stall
//
// One item per clock while busy is low, through a parse stage, three day-count
// stages (checks, multiplies, sum) and one seconds multiply.
// The slowest stage holds one 22 by 17 bit product.
// Synchronous reset clears every valid bit and raises busy for its duration.
// Nothing stalls: the receiver takes each result in the cycle it appears.
`default_nettype none

module date_text_to_epoch_seconds (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  dtes_pkg::req_type req_item,
   output logic              rsp_valid,
   output dtes_pkg::rsp_type rsp_item
);

   logic busy_ff;
   logic accept;

   dtes_pkg::parse_type parsed;
   dtes_pkg::days_type  days;

   // Hold busy through reset; the pipeline never backs up after that
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   dtes_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .parsed   (parsed)
   );

   dtes_days u_days (
      .clock    (clock),
      .reset    (reset),
      .parsed   (parsed),
      .days_out (days)
   );

   dtes_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .days_in   (days),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Every accepted item reaches the output
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("accepted item did not reach the output");

   // No result without a matching accepted item
   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("result without a matching item");

   // A reject always carries zero seconds
   a_reject_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != dtes_pkg::ST_OK) |-> rsp_item.epoch_seconds == '0)
      else $error("rejected item with nonzero seconds");

   // Seconds never exceed the midnight that opens the last day of year 9999
   a_secs_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.epoch_seconds <= 38'd253402214400)
      else $error("seconds out of range");

endmodule

`default_nettype wire

// ===== bench/date_text_to_epoch_seconds_test.sv =====
// Self-checking bench for date_text_to_epoch_seconds: DD/MM/YYYY text items in,
// epoch seconds and status out. Depends on dtes_pkg and the block's RTL only.
// An in-bench calendar predictor queues expected results; a monitor compares.
`default_nettype none

module date_text_to_epoch_seconds_test;
   import dtes_pkg::*;

   localparam int ResetCycles   = 10;
   localparam int DrainCycles   = 8;     // pipeline is five deep, leave margin
   localparam int WatchdogLimit = 3000;  // cycles with neither an item nor a result

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   req_type req_item  = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   rsp_type pending_epochs[$];   // expected results, oldest first
   int      error_count = 0;
   int      quiet_cycles = 0;

   date_text_to_epoch_seconds dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Calendar predictor
   // ------------------------------------------------------------------

   function automatic bit is_ascii_digit(input logic [7:0] c);
      return c >= ZeroChar && c <= NineChar;
   endfunction

   function automatic longint digit_of(input logic [7:0] c);
      return longint'(c) - longint'(ZeroChar);
   endfunction

   // Days from 1970-01-01 to y-m-d, counting years from March so the leap
   // day falls at the end; negative before the epoch.
   function automatic longint civil_day_number(input longint y, input longint m,
                                               input longint d);
      longint shifted_year, era, year_of_era, march_month, day_of_year, day_of_era;
      shifted_year = (m <= 2) ? y - 1 : y;
      era          = (shifted_year >= 0 ? shifted_year : shifted_year - 399) / 400;
      year_of_era  = shifted_year - era * 400;
      march_month  = (m > 2) ? m - 3 : m + 9;
      day_of_year  = (153 * march_month + 2) / 5 + d - 1;
      day_of_era   = year_of_era * 365 + year_of_era / 4 - year_of_era / 100
                     + day_of_year;
      return era * 146097 + day_of_era - longint'(EpochShift);
   endfunction

   // Checks go in order: separators, digits, month, day, then the epoch bound.
   function automatic rsp_type civil_epoch_result(input req_type t);
      rsp_type r;
      longint  d, m, y, days;
      r.epoch_seconds = '0;
      r.status        = ST_OK;
      if (t.first_separator_char != SlashChar || t.second_separator_char != SlashChar)
         r.status = ST_SEP;
      else if (!(is_ascii_digit(t.day_tens_char) && is_ascii_digit(t.day_ones_char) &&
                 is_ascii_digit(t.month_tens_char) && is_ascii_digit(t.month_ones_char) &&
                 is_ascii_digit(t.year_thousands_char) &&
                 is_ascii_digit(t.year_hundreds_char) &&
                 is_ascii_digit(t.year_tens_char) && is_ascii_digit(t.year_ones_char)))
         r.status = ST_DIGIT;
      if (r.status == ST_OK) begin
         d = digit_of(t.day_tens_char) * 10 + digit_of(t.day_ones_char);
         m = digit_of(t.month_tens_char) * 10 + digit_of(t.month_ones_char);
         y = digit_of(t.year_thousands_char) * 1000 + digit_of(t.year_hundreds_char) * 100
             + digit_of(t.year_tens_char) * 10 + digit_of(t.year_ones_char);
         if (m < 1 || m > 12)
            r.status = ST_MONTH;
         else if (d < 1 || d > 31)
            r.status = ST_DAY;
         else begin
            days = civil_day_number(y, m, d);
            if (days < 0)
               r.status = ST_EARLY;
            else
               r.epoch_seconds = SecsWidth'(days * longint'(SecsPerDay));
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Item builders
   // ------------------------------------------------------------------

   // Well-formed text from numbers; day and month may go up to 99 so range
   // errors can be built with digit characters.
   function automatic req_type date_text(input int d, input int m, input int y);
      req_type t;
      t.day_tens_char         = ZeroChar + 8'(d / 10);
      t.day_ones_char         = ZeroChar + 8'(d % 10);
      t.first_separator_char  = SlashChar;
      t.month_tens_char       = ZeroChar + 8'(m / 10);
      t.month_ones_char       = ZeroChar + 8'(m % 10);
      t.second_separator_char = SlashChar;
      t.year_thousands_char   = ZeroChar + 8'(y / 1000);
      t.year_hundreds_char    = ZeroChar + 8'((y / 100) % 10);
      t.year_tens_char        = ZeroChar + 8'((y / 10) % 10);
      t.year_ones_char        = ZeroChar + 8'(y % 10);
      return t;
   endfunction

   // Mostly plausible dates with random content, biased toward the epoch
   // boundary and month ends; a share of day and month values out of range.
   function automatic req_type random_date_text();
      int d, m, y, pick;
      pick = $urandom_range(99);
      if (pick < 40)      y = $urandom_range(2100, 1970);
      else if (pick < 60) y = $urandom_range(1975, 1965);
      else                y = $urandom_range(9999, 0);
      m = ($urandom_range(99) < 88) ? $urandom_range(12, 1) : $urandom_range(19, 0);
      if ($urandom_range(99) < 20)      d = $urandom_range(31, 28);
      else if ($urandom_range(99) < 88) d = $urandom_range(31, 1);
      else                              d = $urandom_range(39, 0);
      return date_text(d, m, y);
   endfunction

   // Overwrite one character with a random byte; position 0 is the year ones.
   function automatic req_type corrupt_one_char(input req_type t);
      int unsigned pos;
      pos = $urandom_range(9);
      t[8 * pos +: 8] = 8'($urandom_range(255));
      return t;
   endfunction

   function automatic req_type random_bytes();
      req_type t;
      for (int i = 0; i < 10; i++)
         t[8 * i +: 8] = 8'($urandom_range(255));
      return t;
   endfunction

   // ------------------------------------------------------------------
   // Driver side
   // ------------------------------------------------------------------

   // Present one item and hold it until the block takes it. Called at a
   // rising edge; returns at the edge of acceptance with start still high.
   task automatic send_date(input req_type t);
      start    <= 1'b1;
      req_item <= t;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      pending_epochs.push_back(civil_epoch_result(t));
   endtask

   // Drop start for a random run of cycles; idle_pct is the chance per cycle.
   task automatic idle_sender(input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // Hold off until every queued result has come back.
   task automatic drain_results();
      start <= 1'b0;
      while (pending_epochs.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   task automatic test_directed_dates();
      req_type t;
      send_date(date_text(1, 1, 1970));      // epoch day itself: zero seconds, ok
      send_date(date_text(2, 1, 1970));
      send_date(date_text(31, 12, 1969));    // last day before the epoch
      send_date(date_text(31, 12, 9999));    // largest representable date
      send_date(date_text(1, 1, 0));         // year zero
      send_date(date_text(1, 3, 9));
      send_date(date_text(31, 2, 2001));     // rolls into March
      send_date(date_text(29, 2, 2000));     // leap century
      send_date(date_text(29, 2, 2100));     // non-leap century, rolls over
      send_date(date_text(0, 1, 2000));      // day zero
      send_date(date_text(32, 1, 2000));
      send_date(date_text(15, 0, 2000));     // month zero
      send_date(date_text(15, 13, 2000));
      send_date(date_text(99, 99, 2000));    // month checked before day
      t = date_text(1, 1, 2000);
      t.first_separator_char = 8'h2E;
      send_date(t);
      t = date_text(1, 1, 2000);
      t.second_separator_char = 8'h5C;
      send_date(t);
      t = '1;                                // separator beats non-digit
      send_date(t);
      t = date_text(1, 1, 2000);
      t.day_tens_char = SlashChar;           // just below '0'
      send_date(t);
      t = date_text(1, 1, 2000);
      t.year_ones_char = 8'h3A;              // just above '9'
      send_date(t);
      t = date_text(1, 1, 2000);
      t.month_ones_char = 8'h00;
      send_date(t);
      t = date_text(1, 1, 2000);
      t.year_thousands_char = 8'hFF;
      send_date(t);
      t = date_text(1, 1, 2000);
      t.day_ones_char = 8'hB1;               // '1' with the top bit set
      send_date(t);
      drain_results();
   endtask

   // Random mix: well-formed dates dominate, then single bad characters,
   // then pure noise. Every 80 items a short burst runs with no idling.
   task automatic test_random_dates(input int count, input int idle_pct);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 70)      send_date(random_date_text());
         else if (pick < 85) send_date(corrupt_one_char(random_date_text()));
         else                send_date(random_bytes());
         if ((n % 80) >= 12) idle_sender(idle_pct);
      end
      drain_results();
   endtask

   task automatic test_streaming_dates();
      test_random_dates(560, 0);
   endtask

   task automatic test_sparse_dates();
      test_random_dates(560, 88);
   endtask

   task automatic test_lightly_idle_dates();
      test_random_dates(560, 13);
   endtask

   // ------------------------------------------------------------------
   // Result monitor
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_epochs.size() == 0)
            report_mismatch($sformatf("result with none pending: secs %0d status %0d",
                                      rsp_item.epoch_seconds, rsp_item.status));
         else begin
            want = pending_epochs.pop_front();
            if (rsp_item.epoch_seconds !== want.epoch_seconds)
               report_mismatch($sformatf("epoch_seconds got %0d want %0d",
                                         rsp_item.epoch_seconds, want.epoch_seconds));
            if (rsp_item.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_item.status, want.status));
         end
      end
   end

   // Watchdog: count cycles in which neither an item nor a result moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WatchdogLimit) begin
            $display("watchdog expired with %0d results pending", pending_epochs.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_dates();
      test_streaming_dates();
      test_sparse_dates();
      test_lightly_idle_dates();
      // Let any stray result surface before the verdict.
      repeat (DrainCycles) @(posedge clock);
      if (pending_epochs.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_epochs.size()));
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
